/* rtl/core/rss_pkg.sv */
// Shared constants, widths and control types for the running sample statistics block.
// Used by running_sample_statistics, rss_cs_unit and rss_port_check; depends on nothing.

package rss_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_BITS  = 16;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Port widths of the result fields.
    localparam int TOTAL_W = 16;
    localparam int MEAN_W  = 24;
    localparam int EXT_W   = 16;
    localparam int DEV_W   = 23;

    // Running sums.
    localparam int SUM_W   = SAMPLE_BITS + COUNT_BITS;
    localparam int SQ_W    = 2 * SAMPLE_BITS + COUNT_BITS;
    localparam int SQ_HALF = SQ_W / 2;

    // Shared multiplier and the accumulator for N*S2 - S1*S1.
    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = PROD_W + 2;

    // Fraction bits of the mean and of the deviation.
    localparam int MEAN_FRAC = 8;
    localparam int ROOT_FRAC = 8;

    // Radicand handling: the difference is kept to D_W bits and scaled by 2^(2*ROOT_FRAC).
    localparam int D_W    = 62;
    localparam int NUM_W  = 64;
    localparam int ITER_W = (NUM_W + 2 * ROOT_FRAC) / 2;
    localparam int RAD_W  = 2 * ITER_W;
    localparam int REM_W  = ITER_W + 2;
    localparam int CNT_W  = $clog2(ITER_W + 1);

    typedef enum logic {
        OP_DIV,
        OP_SQRT
    } rss_op_t;

    typedef struct packed {
        logic    start;
        rss_op_t op;
    } rss_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rss_stat_t;

endpackage

/* rtl/core/rss_cs_unit.sv */
// Shared shift, compare and subtract unit: restoring division or integer square root,
// one result bit per cycle. Depends on rss_pkg.

module rss_cs_unit
    import rss_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  rss_cmd_t               cmd,
    input  logic [NUM_W-1:0]       opnd,
    input  logic [COUNT_BITS-1:0]  den,
    output rss_stat_t              stat,
    output logic [ITER_W-1:0]      result
);

    logic [RAD_W-1:0]  src_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ITER_W-1:0] q_reg;
    logic [CNT_W-1:0]  cnt_reg;
    rss_op_t           op_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [REM_W-1:0]  rem_shift;
    logic [REM_W-1:0]  trial;
    logic [REM_W:0]    diff;
    logic              fits;
    logic [REM_W-1:0]  rem_next;
    logic [ITER_W-1:0] q_next;
    logic [RAD_W-1:0]  src_next;

    // The square root brings in two radicand bits a step and tries 4*root+1;
    // the division brings in one dividend bit and tries the divisor.
    always_comb
    begin
        if (op_reg == OP_SQRT)
        begin
            rem_shift = {rem_reg[REM_W-3:0], src_reg[RAD_W-1 -: 2]};
            trial     = {q_reg, 2'b01};
            src_next  = {src_reg[RAD_W-3:0], 2'b00};
        end
        else
        begin
            rem_shift = {rem_reg[REM_W-2:0], src_reg[RAD_W-1]};
            trial     = {{(REM_W-COUNT_BITS){1'b0}}, den};
            src_next  = {src_reg[RAD_W-2:0], 1'b0};
        end
        diff     = {1'b0, rem_shift} - {1'b0, trial};
        fits     = ~diff[REM_W];
        rem_next = fits ? diff[REM_W-1:0] : rem_shift;
        q_next   = {q_reg[ITER_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg  <= '0;
            rem_reg  <= '0;
            q_reg    <= '0;
            cnt_reg  <= '0;
            op_reg   <= OP_DIV;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                op_reg   <= cmd.op;
                rem_reg  <= '0;
                q_reg    <= '0;
                cnt_reg  <= CNT_W'(ITER_W);
                busy_reg <= 1'b1;
                if (cmd.op == OP_SQRT)
                begin
                    src_reg <= {opnd, {(2*ROOT_FRAC){1'b0}}};
                end
                else
                begin
                    src_reg <= {opnd[ITER_W-1:0], {ITER_W{1'b0}}};
                end
            end
            else if (busy_reg)
            begin
                src_reg <= src_next;
                rem_reg <= rem_next;
                q_reg   <= q_next;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = q_reg;

endmodule

/* rtl/core/running_sample_statistics.sv */
// Running count, mean, minimum, maximum and population deviation of a sample stream.
// Depends on rss_pkg and rss_cs_unit.
//
//   channel | signals                              | direction
//   input   | in_valid, in_stall, sample           | one sample per transaction
//   output  | out_valid, out_stall, sample_total,  | one result per transaction
//           | mean_value, lowest_seen,             |
//           | highest_seen, std_deviation, dropped |
//
// A transaction runs from acceptance to a loaded result through updates and multiplies on
// the shared 32x32 multiplier, three passes (start, steps, done) through the shared
// compare-subtract unit (square root, deviation divide, mean divide), and a final load of
// the output register.
// in_stall is high from acceptance until the result is loaded, so the block takes no new
// sample until the result of the previous one has been loaded.
// A result held by out_stall does not block acceptance of the next sample; the following
// result then waits, with in_stall still high, until the held one is taken.
// Reset clears the count, the sums, the minimum, the maximum and the output valid.

module running_sample_statistics
    import rss_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [15:0]         sample,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [TOTAL_W-1:0]  sample_total,
    output logic [MEAN_W-1:0]   mean_value,
    output logic [EXT_W-1:0]    lowest_seen,
    output logic [EXT_W-1:0]    highest_seen,
    output logic [DEV_W-1:0]    std_deviation,
    output logic                dropped
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQS,
        ST_UPDATE,
        ST_MAG,
        ST_MUL_S1,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ACC,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_DEV_GO,
        ST_DEV_WAIT,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_OUT
    } state_t;

    state_t                  state_reg;
    logic [SAMPLE_BITS-1:0]  sample_reg;
    logic [COUNT_BITS-1:0]   count_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [SQ_W-1:0]         square_sum_reg;
    logic [SAMPLE_BITS-1:0]  min_reg;
    logic [SAMPLE_BITS-1:0]  max_reg;
    logic [SUM_W-1:0]        mag_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [ACC_W-1:0]        acc_reg;
    logic                    drop_reg;
    logic [DEV_W-1:0]        dev_reg;
    logic [MEAN_W-1:0]       mean_reg;

    logic                    out_valid_reg;
    logic [TOTAL_W-1:0]      total_out_reg;
    logic [MEAN_W-1:0]       mean_out_reg;
    logic [EXT_W-1:0]        low_out_reg;
    logic [EXT_W-1:0]        high_out_reg;
    logic [DEV_W-1:0]        dev_out_reg;
    logic                    drop_out_reg;

    logic [SAMPLE_BITS-1:0]  smag;
    logic                    sum_neg;
    logic [MUL_W-1:0]        mul_a;
    logic [MUL_W-1:0]        mul_b;
    logic [NUM_W-1:0]        radicand;
    logic [MEAN_W-1:0]       quot_low;
    rss_cmd_t                cmd;
    rss_stat_t               stat;
    logic [NUM_W-1:0]        opnd;
    logic [ITER_W-1:0]       result;

    assign smag    = sample_reg[SAMPLE_BITS-1] ? (~sample_reg + 1'b1) : sample_reg;
    assign sum_neg = sum_reg[SUM_W-1];

    // A negative difference can only come from wrapped sums; it counts as zero.
    assign radicand = acc_reg[ACC_W-1] ? '0 : {{(NUM_W-D_W){1'b0}}, acc_reg[D_W-1:0]};
    assign quot_low = result[MEAN_W-1:0];

    always_comb
    begin
        case (state_reg)
            ST_SQS:
            begin
                mul_a = MUL_W'(smag);
                mul_b = MUL_W'(smag);
            end
            ST_MUL_S1:
            begin
                mul_a = MUL_W'(mag_reg);
                mul_b = MUL_W'(mag_reg);
            end
            ST_MUL_LO:
            begin
                mul_a = MUL_W'(count_reg);
                mul_b = MUL_W'(square_sum_reg[SQ_HALF-1:0]);
            end
            ST_MUL_HI:
            begin
                mul_a = MUL_W'(count_reg);
                mul_b = MUL_W'(square_sum_reg[SQ_W-1:SQ_HALF]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        cmd.start = 1'b0;
        cmd.op    = OP_DIV;
        opnd      = '0;
        case (state_reg)
            ST_SQRT_GO:
            begin
                cmd.start = 1'b1;
                cmd.op    = OP_SQRT;
                opnd      = radicand;
            end
            ST_DEV_GO:
            begin
                cmd.start = 1'b1;
                opnd      = NUM_W'(result);
            end
            ST_MEAN_GO:
            begin
                cmd.start = 1'b1;
                opnd      = NUM_W'({mag_reg, {MEAN_FRAC{1'b0}}});
            end
            default:
            begin
                cmd.start = 1'b0;
            end
        endcase
    end

    rss_cs_unit u_cs_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .opnd   (opnd),
        .den    (count_reg),
        .stat   (stat),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            sample_reg     <= '0;
            count_reg      <= '0;
            sum_reg        <= '0;
            square_sum_reg <= '0;
            min_reg        <= '0;
            max_reg        <= '0;
            mag_reg        <= '0;
            prod_reg       <= '0;
            acc_reg        <= '0;
            drop_reg       <= 1'b0;
            dev_reg        <= '0;
            mean_reg       <= '0;
            out_valid_reg  <= 1'b0;
            total_out_reg  <= '0;
            mean_out_reg   <= '0;
            low_out_reg    <= '0;
            high_out_reg   <= '0;
            dev_out_reg    <= '0;
            drop_out_reg   <= 1'b0;
        end
        else
        begin
            prod_reg <= mul_a * mul_b;

            // In ST_OUT the output register is either reloaded or held below.
            if (out_valid_reg && !out_stall && state_reg != ST_OUT)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        sample_reg <= sample[SAMPLE_BITS-1:0];
                        state_reg  <= ST_SQS;
                    end
                end
                ST_SQS:
                begin
                    state_reg <= ST_UPDATE;
                end
                ST_UPDATE:
                begin
                    drop_reg <= (count_reg == COUNT_MAX);
                    if (count_reg != COUNT_MAX)
                    begin
                        if (count_reg == '0)
                        begin
                            min_reg <= sample_reg;
                            max_reg <= sample_reg;
                        end
                        else
                        begin
                            if ($signed(sample_reg) < $signed(min_reg))
                            begin
                                min_reg <= sample_reg;
                            end
                            if ($signed(sample_reg) > $signed(max_reg))
                            begin
                                max_reg <= sample_reg;
                            end
                        end
                        count_reg      <= count_reg + 1'b1;
                        sum_reg        <= sum_reg + {{(SUM_W-SAMPLE_BITS){sample_reg[SAMPLE_BITS-1]}},
                                                     sample_reg};
                        square_sum_reg <= square_sum_reg + SQ_W'(prod_reg[2*SAMPLE_BITS-1:0]);
                    end
                    state_reg <= ST_MAG;
                end
                ST_MAG:
                begin
                    mag_reg   <= sum_neg ? (~sum_reg + 1'b1) : sum_reg;
                    state_reg <= ST_MUL_S1;
                end
                ST_MUL_S1:
                begin
                    state_reg <= ST_MUL_LO;
                end
                ST_MUL_LO:
                begin
                    // prod_reg holds S1*S1 here; the accumulator starts at its negation.
                    acc_reg   <= '0 - ACC_W'(prod_reg);
                    state_reg <= ST_MUL_HI;
                end
                ST_MUL_HI:
                begin
                    acc_reg   <= acc_reg + ACC_W'(prod_reg);
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    acc_reg   <= acc_reg + (ACC_W'(prod_reg) << SQ_HALF);
                    state_reg <= ST_SQRT_GO;
                end
                ST_SQRT_GO:
                begin
                    state_reg <= ST_SQRT_WAIT;
                end
                ST_SQRT_WAIT:
                begin
                    if (stat.done)
                    begin
                        state_reg <= ST_DEV_GO;
                    end
                end
                ST_DEV_GO:
                begin
                    state_reg <= ST_DEV_WAIT;
                end
                ST_DEV_WAIT:
                begin
                    if (stat.done)
                    begin
                        dev_reg   <= result[DEV_W-1:0];
                        state_reg <= ST_MEAN_GO;
                    end
                end
                ST_MEAN_GO:
                begin
                    state_reg <= ST_MEAN_WAIT;
                end
                ST_MEAN_WAIT:
                begin
                    if (stat.done)
                    begin
                        mean_reg  <= sum_neg ? ('0 - quot_low) : quot_low;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        total_out_reg <= TOTAL_W'(count_reg);
                        mean_out_reg  <= mean_reg;
                        low_out_reg   <= EXT_W'(min_reg);
                        high_out_reg  <= EXT_W'(max_reg);
                        dev_out_reg   <= dev_reg;
                        drop_out_reg  <= drop_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign sample_total  = total_out_reg;
    assign mean_value    = mean_out_reg;
    assign lowest_seen   = low_out_reg;
    assign highest_seen  = high_out_reg;
    assign std_deviation = dev_out_reg;
    assign dropped       = drop_out_reg;

endmodule

/* rtl/core/rss_port_check.sv */
// Port-level checks for running_sample_statistics, attached to it by the bind below.
// Depends on rss_pkg and on the top level's port names.

module rss_port_check
    import rss_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input logic [TOTAL_W-1:0]  sample_total,
    input logic [MEAN_W-1:0]   mean_value,
    input logic [EXT_W-1:0]    lowest_seen,
    input logic [EXT_W-1:0]    highest_seen,
    input logic                dropped
);

    // A stalled result stays offered, and its total and mean stay unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample_total) && $stable(mean_value))
        else $error("stalled result changed or withdrawn");

    // Every reported result covers at least one sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sample_total != '0)
        else $error("result reported with an empty count");

    // A sample is dropped only when the count is saturated.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dropped |-> sample_total == TOTAL_W'(COUNT_MAX))
        else $error("drop flagged below the saturated count");

    // The tracked minimum never exceeds the tracked maximum.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $signed(lowest_seen) <= $signed(highest_seen))
        else $error("minimum above maximum");

endmodule

bind running_sample_statistics rss_port_check u_port_check (.*);

/* dv/tb_top.sv */
// Self-checking bench for running_sample_statistics: random and directed samples,
// a running-statistics predictor, random idling on both channels and a watchdog.
// Depends on rss_pkg and the RTL of running_sample_statistics.

module tb_top;
    import rss_pkg::*;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int LONG_HOLD      = 1000;
    localparam int LONG_HOLD_AT   = 300;
    localparam int DRAIN_AT       = 1000;
    localparam int RANDOM_ITEMS   = 1630;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic [MEAN_W-1:0]  mean;
        logic [EXT_W-1:0]   low;
        logic [EXT_W-1:0]   high;
        logic [DEV_W-1:0]   dev;
        logic               drop;
    } stats_t;

    typedef struct {
        logic [15:0] value;
        bit          drain_first;
    } feed_item_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [15:0]         sample;
    logic                out_valid;
    logic                out_stall;
    logic [TOTAL_W-1:0]  sample_total;
    logic [MEAN_W-1:0]   mean_value;
    logic [EXT_W-1:0]    lowest_seen;
    logic [EXT_W-1:0]    highest_seen;
    logic [DEV_W-1:0]    std_deviation;
    logic                dropped;

    feed_item_t  feed_q[$];
    stats_t      expected_stats[$];

    // Predictor state, mirrors the accumulators of the block.
    logic [COUNT_BITS-1:0] run_count = '0;
    logic signed [63:0]    run_sum   = '0;
    logic [63:0]           run_sq    = '0;
    logic signed [15:0]    run_min   = '0;
    logic signed [15:0]    run_max   = '0;

    int unsigned items_taken;
    int unsigned results_done;
    int unsigned send_gap;
    int unsigned rx_hold;
    int unsigned idle_cycles;
    int unsigned error_count  = 0;
    int unsigned report_count = 0;
    int unsigned drops_seen   = 0;
    logic [DEV_W-1:0] peak_dev = '0;

    running_sample_statistics DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sample_total  (sample_total),
        .mean_value    (mean_value),
        .lowest_seen   (lowest_seen),
        .highest_seen  (highest_seen),
        .std_deviation (std_deviation),
        .dropped       (dropped)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // floor(sqrt(v)), one result bit per step.
    function automatic logic [39:0] root_floor(input logic [79:0] v);
        logic [79:0] rem;
        logic [79:0] res;
        logic [79:0] probe;
        rem   = v;
        res   = '0;
        probe = 80'd1 << 78;
        for (int i = 0; i < 40; i++)
        begin
            if (rem >= res + probe)
            begin
                rem = rem - (res + probe);
                res = (res >> 1) + probe;
            end
            else
            begin
                res = res >> 1;
            end
            probe = probe >> 2;
        end
        return res[39:0];
    endfunction

    // Quiet windows give long runs without any idling on either side.
    function automatic int unsigned idle_draw(input int unsigned idx);
        if ((idx / 150) % 5 == 2)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    task automatic predict_stats(input logic [15:0] raw);
        logic signed [63:0] s;
        logic [63:0]        mag;
        logic [63:0]        avg;
        logic [63:0]        nsq;
        logic [63:0]        s1sq;
        logic [63:0]        diff;
        logic [39:0]        root;
        logic [39:0]        dev;
        logic               drop;
        stats_t             nxt;
        s    = {{48{raw[15]}}, raw};
        drop = (run_count == COUNT_MAX);
        if (!drop)
        begin
            if (run_count == '0)
            begin
                run_min = signed'(raw);
                run_max = signed'(raw);
            end
            else
            begin
                if (signed'(raw) < run_min)
                    run_min = signed'(raw);
                if (signed'(raw) > run_max)
                    run_max = signed'(raw);
            end
            run_count = run_count + 1'b1;
            run_sum   = run_sum + s;
            run_sq    = run_sq + 64'(s * s);
        end
        mag  = run_sum[63] ? 64'(-run_sum) : 64'(run_sum);
        avg  = (mag << 8) / {48'd0, run_count};
        if (run_sum[63])
            avg = -avg;
        nsq  = {48'd0, run_count} * run_sq;
        s1sq = mag * mag;
        diff = (nsq >= s1sq) ? nsq - s1sq : 64'd0;
        diff[63:62] = 2'b00;
        root = root_floor({diff, 16'd0});
        dev  = root / {24'd0, run_count};
        nxt.total = run_count;
        nxt.mean  = avg[MEAN_W-1:0];
        nxt.low   = run_min;
        nxt.high  = run_max;
        nxt.dev   = dev[DEV_W-1:0];
        nxt.drop  = drop;
        expected_stats = {expected_stats, nxt};
    endtask

    task automatic check_result();
        stats_t exp_r;
        if (expected_stats.size() == 0)
        begin
            error_count++;
            if (report_count < MAX_REPORTS)
                $display("ERROR: result with count %0d arrived with nothing pending",
                         sample_total);
            report_count++;
            return;
        end
        exp_r = expected_stats.pop_front();
        if (sample_total !== exp_r.total || mean_value !== exp_r.mean
            || lowest_seen !== exp_r.low || highest_seen !== exp_r.high
            || std_deviation !== exp_r.dev || dropped !== exp_r.drop)
        begin
            error_count++;
            if (report_count < MAX_REPORTS)
            begin
                $display("ERROR: result %0d expected total=%0d mean=%h min=%0d max=%0d dev=%h drop=%b",
                         results_done, exp_r.total, exp_r.mean, $signed(exp_r.low),
                         $signed(exp_r.high), exp_r.dev, exp_r.drop);
                $display("       actual            total=%0d mean=%h min=%0d max=%0d dev=%h drop=%b",
                         sample_total, mean_value, $signed(lowest_seen),
                         $signed(highest_seen), std_deviation, dropped);
            end
            report_count++;
        end
        if (exp_r.dev > peak_dev)
            peak_dev = exp_r.dev;
        if (exp_r.drop)
            drops_seen++;
    endtask

    // Sender: one gap draw per item, valid held steady while stalled.
    always @(posedge clk or negedge rst_n)
    begin : sample_feed
        feed_item_t item;
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            sample      <= '0;
            send_gap    <= 0;
            items_taken <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_stats(sample);
                items_taken <= items_taken + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (feed_q.size() != 0
                         && !(feed_q[0].drain_first
                              && (in_valid || items_taken != results_done)))
                begin
                    item = feed_q.pop_front();
                    in_valid <= 1'b1;
                    sample   <= item.value;
                    send_gap <= idle_draw(items_taken);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver and checker: one stall draw per result, one long hold-off.
    always @(posedge clk or negedge rst_n)
    begin : result_check
        int unsigned next_hold;
        if (!rst_n)
        begin
            out_stall    <= 1'b0;
            rx_hold      <= 0;
            results_done <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                check_result();
                results_done <= results_done + 1;
                next_hold = (results_done == LONG_HOLD_AT) ? LONG_HOLD
                                                           : idle_draw(results_done);
            end
            else
            begin
                next_hold = (rx_hold != 0) ? rx_hold - 1 : 0;
            end
            rx_hold   <= next_hold;
            out_stall <= (next_hold != 0);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : watchdog
        @(posedge rst_n);
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        logic [15:0] directed_values[$];
        feed_item_t  item;
        int          center;
        int unsigned pick;
        int          val;
        int unsigned missing;

        rst_n = 1'b0;

        // Extremes first: a zero start, full-scale swings, sign edges, bit patterns.
        directed_values = {16'h0000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'hFFFF,
                           16'h0001, 16'h0000, 16'h0064, 16'hFF9C, 16'h5555, 16'hAAAA,
                           16'h7FFE, 16'h8001, 16'h0003, 16'h0003, 16'h0003, 16'h8000,
                           16'h8000, 16'h8000};
        foreach (directed_values[i])
        begin
            item.value       = directed_values[i];
            item.drain_first = 1'b0;
            feed_q = {feed_q, item};
        end

        center = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 40 == 0)
                center = int'($urandom_range(0, 65529)) - 32765;
            pick = $urandom_range(0, 9);
            if (pick <= 3)
                val = int'($urandom_range(0, 65535)) - 32768;
            else if (pick <= 5)
                val = int'($urandom_range(0, 600)) - 300;
            else if (pick == 6)
                val = ($urandom_range(0, 1) != 0) ? 32767 - int'($urandom_range(0, 1))
                                                  : -32768 + int'($urandom_range(0, 1));
            else
                val = center + int'($urandom_range(0, 6)) - 3;
            item.value       = val[15:0];
            item.drain_first = (i == DRAIN_AT);
            feed_q = {feed_q, item};
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (feed_q.size() != 0 || in_valid || items_taken != results_done)
            @(posedge clk);
        repeat (200) @(posedge clk);

        missing = expected_stats.size();
        if (missing != 0)
            $display("ERROR: %0d results never arrived", missing);

        $display("Ran %0d samples through the block, %0d results checked, %0d dropped.",
                 items_taken, results_done, drops_seen);
        $display("Final count %0d, largest deviation seen %0d/256, %0d mismatches.",
                 run_count, peak_dev, error_count + missing);
        if (error_count == 0 && missing == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* files.f */
rtl/core/rss_pkg.sv
rtl/core/rss_cs_unit.sv
rtl/core/running_sample_statistics.sv
rtl/core/rss_port_check.sv
dv/tb_top.sv
